// ----- hw/rtl/ptu_pkg.sv -----
`default_nettype none
package ptu_pkg;

    localparam int DIV_W = 16;
    localparam int STEP_W = DIV_W + 1;
    localparam int FADE_N = 5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] start_position;
        logic [47:0] start_velocity;
        logic [47:0] acceleration;
        logic [15:0] lifetime_frames;
        logic [15:0] start_size;
        logic [15:0] end_size;
        logic [63:0] start_rgba;
        logic [63:0] end_rgba;
    } in_item_t;

    typedef struct packed {
        logic [47:0] position_xyz;
        logic [15:0] size_now;
        logic [63:0] rgba_now;
        logic [6:0]  live_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [47:0]             pos;
        logic [47:0]             vel;
        logic [47:0]             acc;
        logic [15:0]             age;
        logic [15:0]             life;
        logic [15:0]             size;
        logic [STEP_W-1:0]       size_step;
        logic [63:0]             color;
        logic [3:0][STEP_W-1:0]  color_step;
    } rec_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    function automatic logic [47:0] vec_add(input logic [47:0] a, input logic [47:0] b);
        logic [47:0] r;
        logic [16:0] s;
        for (int k = 0; k < 3; k++) begin
            s = {a[16*k+15], a[16*k +: 16]} + {b[16*k+15], b[16*k +: 16]};
            if (s[16] != s[15]) begin
                r[16*k +: 16] = s[16] ? 16'h8000 : 16'h7FFF;
            end else begin
                r[16*k +: 16] = s[15:0];
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] fade(input logic [15:0] v, input logic [STEP_W-1:0] st);
        logic [17:0] d;
        d = {2'b00, v} - {st[STEP_W-1], st};
        if (d[17]) begin
            return 16'h0000;
        end else if (d[16]) begin
            return 16'hFFFF;
        end
        return d[15:0];
    endfunction

    function automatic rec_t advance(input rec_t r);
        rec_t n;
        n = r;
        n.age = (r.age == 16'hFFFF) ? r.age : r.age + 16'd1;
        n.vel = vec_add(r.vel, r.acc);
        n.pos = vec_add(r.pos, n.vel);
        n.size = fade(r.size, r.size_step);
        for (int k = 0; k < 4; k++) begin
            n.color[16*k +: 16] = fade(r.color[16*k +: 16], r.color_step[k]);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/particle_table_update.sv -----
`default_nettype none
// An add runs five passes of the shared divider, one per fade channel, each a start,
// sixteen iterations and a done, then one write.
// A tick reads and writes each live particle to age and compact the table, then reads
// each kept result back, newest first, and waits there while the result side stalls.
// Clear and the unused code finish in IDLE. One item is handled at a time.
// Synchronous active-low reset empties the table; stored records need no clearing.
module particle_table_update_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ptu_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ptu_pkg::out_item_t       m_data
);
    import ptu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        IDLE, DIV_START, DIV_WAIT, ADD_WR, TK_RD, TK_WR, EM_RD, EM_LOAD
    } state_t;

    state_t                     state_reg;
    in_item_t                   in_reg;
    logic [CW-1:0]              live_reg;
    logic [CW-1:0]              idx_reg;
    logic [CW-1:0]              kept_reg;
    logic [2:0]                 fsel_reg;
    logic [FADE_N-1:0][STEP_W-1:0] step_reg;
    logic                       m_valid_reg;
    out_item_t                  m_data_reg;

    rec_t                       mem [CAPACITY];
    rec_t                       rd_reg;
    rec_t                       wr_data;
    rec_t                       adv;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic                       mem_re;
    logic                       alive;
    logic                       slot_free;
    logic [CW-1:0]              kept_next;

    div_req_t                   dreq;
    logic                       div_done;
    logic [DIV_W-1:0]           div_q;
    logic [DIV_W-1:0]           f_start;
    logic [DIV_W-1:0]           f_end;
    logic [DIV_W-1:0]           f_q;
    logic [STEP_W-1:0]          f_step;

    always_comb begin
        case (fsel_reg)
            3'd0: begin
                f_start = in_reg.start_size;
                f_end = in_reg.end_size;
            end
            3'd1: begin
                f_start = in_reg.start_rgba[15:0];
                f_end = in_reg.end_rgba[15:0];
            end
            3'd2: begin
                f_start = in_reg.start_rgba[31:16];
                f_end = in_reg.end_rgba[31:16];
            end
            3'd3: begin
                f_start = in_reg.start_rgba[47:32];
                f_end = in_reg.end_rgba[47:32];
            end
            default: begin
                f_start = in_reg.start_rgba[63:48];
                f_end = in_reg.end_rgba[63:48];
            end
        endcase
    end

    assign dreq.start = (state_reg == DIV_START);
    assign dreq.dividend = (f_start >= f_end) ? f_start - f_end : f_end - f_start;
    assign dreq.divisor = in_reg.lifetime_frames;
    assign f_q = (in_reg.lifetime_frames == '0) ? '0 : div_q;
    assign f_step = (f_start < f_end) ? STEP_W'(0) - {1'b0, f_q} : {1'b0, f_q};

    ptu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (div_done),
        .quotient (div_q)
    );

    assign adv = advance(rd_reg);
    assign alive = rd_reg.age < rd_reg.life;
    assign kept_next = alive ? kept_reg + 1'b1 : kept_reg;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        wr_data.pos = in_reg.start_position;
        wr_data.vel = in_reg.start_velocity;
        wr_data.acc = in_reg.acceleration;
        wr_data.age = '0;
        wr_data.life = in_reg.lifetime_frames;
        wr_data.size = in_reg.start_size;
        wr_data.size_step = step_reg[0];
        wr_data.color = in_reg.start_rgba;
        for (int k = 0; k < 4; k++) begin
            wr_data.color_step[k] = step_reg[k + 1];
        end
        mem_we = 1'b0;
        mem_wa = live_reg[AW-1:0];
        if (state_reg == ADD_WR) begin
            mem_we = 1'b1;
        end else if (state_reg == TK_WR && alive) begin
            mem_we = 1'b1;
            mem_wa = kept_reg[AW-1:0];
            wr_data = adv;
        end
    end

    assign mem_re = (state_reg == TK_RD) || (state_reg == EM_RD);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= wr_data;
        end
        if (mem_re) begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            live_reg <= '0;
            idx_reg <= '0;
            kept_reg <= '0;
            fsel_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != EM_LOAD) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        case (op_t'(s_data.operation))
                            OP_ADD: begin
                                if (live_reg != CW'(CAPACITY)) begin
                                    fsel_reg <= '0;
                                    state_reg <= DIV_START;
                                end
                            end
                            OP_TICK: begin
                                if (live_reg != '0) begin
                                    idx_reg <= '0;
                                    kept_reg <= '0;
                                    state_reg <= TK_RD;
                                end
                            end
                            OP_CLEAR: begin
                                live_reg <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                DIV_START: begin
                    state_reg <= DIV_WAIT;
                end
                DIV_WAIT: begin
                    if (div_done) begin
                        step_reg[fsel_reg] <= f_step;
                        if (fsel_reg == 3'(FADE_N - 1)) begin
                            state_reg <= ADD_WR;
                        end else begin
                            fsel_reg <= fsel_reg + 3'd1;
                            state_reg <= DIV_START;
                        end
                    end
                end
                ADD_WR: begin
                    live_reg <= live_reg + 1'b1;
                    state_reg <= IDLE;
                end
                TK_RD: begin
                    state_reg <= TK_WR;
                end
                TK_WR: begin
                    kept_reg <= kept_next;
                    if (CW'(idx_reg + 1'b1) == live_reg) begin
                        live_reg <= kept_next;
                        if (kept_next == '0) begin
                            state_reg <= IDLE;
                        end else begin
                            idx_reg <= kept_next - 1'b1;
                            state_reg <= EM_RD;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= TK_RD;
                    end
                end
                EM_RD: begin
                    state_reg <= EM_LOAD;
                end
                EM_LOAD: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.position_xyz <= rd_reg.pos;
                        m_data_reg.size_now <= rd_reg.size;
                        m_data_reg.rgba_now <= rd_reg.color;
                        m_data_reg.live_count <= 7'(live_reg);
                        m_data_reg.last <= (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_reg <= IDLE;
                        end else begin
                            idx_reg <= idx_reg - 1'b1;
                            state_reg <= EM_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(CAPACITY))
        else $error("live count above capacity");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == TK_WR) |-> (kept_reg <= idx_reg && idx_reg < live_reg))
        else $error("compaction index out of order");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == DIV_WAIT))
        else $error("divider finished outside an add");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EM_LOAD && slot_free) |=> m_valid_reg)
        else $error("result transfer lost");

endmodule
`default_nettype wire

// ----- hw/rtl/ptu_div.sv -----
`default_nettype none
module ptu_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ptu_pkg::div_req_t         req,
    output logic                           done,
    output logic [ptu_pkg::DIV_W-1:0]      quotient
);
    import ptu_pkg::*;

    logic [DIV_W:0]         rem_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [DIV_W-1:0]       dsr_reg;
    logic [4:0]             cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_W:0]         shifted;
    logic                   fits;

    assign shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign fits = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'(DIV_W);
                rem_reg <= '0;
                quo_reg <= req.dividend;
                dsr_reg <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? shifted - {1'b0, dsr_reg} : shifted;
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ptu_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int MAX_CYCLES = 3000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    particle_table_update_core #(.CAPACITY(CAPACITY)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the particle table.
    logic [47:0] sh_pos [CAPACITY];
    logic [47:0] sh_vel [CAPACITY];
    logic [47:0] sh_acc [CAPACITY];
    logic [15:0] sh_age [CAPACITY];
    logic [15:0] sh_life [CAPACITY];
    logic [15:0] sh_size [CAPACITY];
    int          sh_size_step [CAPACITY];
    logic [63:0] sh_color [CAPACITY];
    int          sh_color_step [CAPACITY][4];
    int          sh_order [CAPACITY];
    int          sh_live = 0;

    in_item_t  pending_items [$];
    out_item_t emitted_particles [$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_ticks = 0;
    int        n_adds = 0;
    int        cycle_count = 0;
    int        tx_gap = 0;
    int        tx_calm = 0;
    int        rx_stall = 0;
    int        rx_calm = 0;

    function automatic int sat_s16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int sat_u16(int v);
        if (v > 65535) return 65535;
        if (v < 0) return 0;
        return v;
    endfunction

    function automatic int fade_step(int from_v, int to_v, int life);
        if (life == 0) return 0;
        if (from_v >= to_v) return (from_v - to_v) / life;
        return -((to_v - from_v) / life);
    endfunction

    function automatic logic [47:0] xyz_add(logic [47:0] a, logic [47:0] b);
        logic [47:0] r;
        int s;
        for (int k = 0; k < 3; k++) begin
            s = sat_s16(int'(signed'(a[16*k +: 16])) + int'(signed'(b[16*k +: 16])));
            r[16*k +: 16] = s[15:0];
        end
        return r;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
        return $urandom_range(0, 17);
    endfunction

    task automatic store_particle(input in_item_t it);
        bit used [CAPACITY];
        int slot;
        int life;
        if (sh_live >= CAPACITY) return;
        for (int i = 0; i < CAPACITY; i++) used[i] = 1'b0;
        for (int i = 0; i < sh_live; i++) used[sh_order[i]] = 1'b1;
        slot = 0;
        while (used[slot]) slot++;
        life = it.lifetime_frames;
        sh_pos[slot]  = it.start_position;
        sh_vel[slot]  = it.start_velocity;
        sh_acc[slot]  = it.acceleration;
        sh_age[slot]  = '0;
        sh_life[slot] = it.lifetime_frames;
        sh_size[slot] = it.start_size;
        sh_size_step[slot] = fade_step(it.start_size, it.end_size, life);
        sh_color[slot] = it.start_rgba;
        for (int k = 0; k < 4; k++) begin
            sh_color_step[slot][k] = fade_step(it.start_rgba[16*k +: 16],
                                               it.end_rgba[16*k +: 16], life);
        end
        for (int i = sh_live; i > 0; i--) sh_order[i] = sh_order[i-1];
        sh_order[0] = slot;
        sh_live++;
    endtask

    task automatic advance_table();
        int kept;
        int s;
        int v;
        out_item_t r;
        kept = 0;
        for (int i = 0; i < sh_live; i++) begin
            s = sh_order[i];
            if (sh_age[s] < sh_life[s]) begin
                sh_order[kept] = s;
                kept++;
            end
        end
        sh_live = kept;
        for (int i = 0; i < sh_live; i++) begin
            s = sh_order[i];
            if (sh_age[s] != 16'hFFFF) sh_age[s] = sh_age[s] + 16'd1;
            sh_vel[s] = xyz_add(sh_vel[s], sh_acc[s]);
            sh_pos[s] = xyz_add(sh_pos[s], sh_vel[s]);
            v = sat_u16(int'(sh_size[s]) - sh_size_step[s]);
            sh_size[s] = v[15:0];
            for (int k = 0; k < 4; k++) begin
                v = sat_u16(int'(sh_color[s][16*k +: 16]) - sh_color_step[s][k]);
                sh_color[s][16*k +: 16] = v[15:0];
            end
            r.position_xyz = sh_pos[s];
            r.size_now     = sh_size[s];
            r.rgba_now     = sh_color[s];
            r.live_count   = 7'(kept);
            r.last         = (i == kept - 1);
            emitted_particles.push_back(r);
        end
    endtask

    task automatic apply_item(input in_item_t it);
        case (op_t'(it.operation))
            OP_ADD: begin
                n_adds++;
                store_particle(it);
            end
            OP_TICK: begin
                n_ticks++;
                advance_table();
            end
            OP_CLEAR: sh_live = 0;
            default: ;
        endcase
    endtask

    // Driver: one transfer at a time, a random gap after each item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready) apply_item(s_data);
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                tx_gap <= draw_wait(tx_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every result transfer and stalls at random.
    always @(posedge aclk) begin
        out_item_t want;
        int stall;
        if (aresetn) begin
            stall = rx_stall;
            if (m_valid && m_ready) begin
                n_results++;
                if (emitted_particles.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    n_errors++;
                end else begin
                    want = emitted_particles.pop_front();
                    if (want.position_xyz !== m_data.position_xyz) begin
                        $display("%0t: position expected %h actual %h", $time,
                                 want.position_xyz, m_data.position_xyz);
                        n_errors++;
                    end
                    if (want.size_now !== m_data.size_now) begin
                        $display("%0t: size expected %h actual %h", $time,
                                 want.size_now, m_data.size_now);
                        n_errors++;
                    end
                    if (want.rgba_now !== m_data.rgba_now) begin
                        $display("%0t: colour expected %h actual %h", $time,
                                 want.rgba_now, m_data.rgba_now);
                        n_errors++;
                    end
                    if (want.live_count !== m_data.live_count) begin
                        $display("%0t: live count expected %0d actual %0d", $time,
                                 want.live_count, m_data.live_count);
                        n_errors++;
                    end
                    if (want.last !== m_data.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, m_data.last);
                        n_errors++;
                    end
                end
                stall = draw_wait(rx_calm);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                rx_stall <= stall - 1;
            end else begin
                m_ready <= 1'b1;
                rx_stall <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_life();
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic queue_item(input op_t op, input logic [15:0] life);
        in_item_t it;
        logic [63:0] r;
        r = rand64();
        it.operation      = op;
        it.start_position = r[47:0];
        r = rand64();
        it.start_velocity = r[47:0];
        r = rand64();
        it.acceleration   = r[47:0];
        it.lifetime_frames = life;
        it.start_size     = 16'($urandom);
        it.end_size       = 16'($urandom);
        it.start_rgba     = rand64();
        it.end_rgba       = rand64();
        pending_items.push_back(it);
    endtask

    task automatic queue_extreme(input logic [15:0] edge_v, input logic [15:0] life);
        in_item_t it;
        it.operation       = OP_ADD;
        it.start_position  = {3{edge_v}};
        it.start_velocity  = {3{edge_v}};
        it.acceleration    = {3{edge_v}};
        it.lifetime_frames = life;
        it.start_size      = (edge_v == 16'h7FFF) ? 16'hFFFF : 16'h0000;
        it.end_size        = ~it.start_size;
        it.start_rgba      = {4{it.start_size}};
        it.end_rgba        = {4{it.end_size}};
        pending_items.push_back(it);
    endtask

    initial begin
        int sel;
        int count;
        for (int i = 0; i < CAPACITY; i++) sh_order[i] = 0;

        queue_item(OP_TICK, 16'd1);
        queue_extreme(16'h7FFF, 16'd3);
        queue_extreme(16'h8000, 16'd4);
        queue_item(OP_ADD, 16'd0);
        queue_item(OP_ADD, 16'hFFFF);
        queue_item(OP_ADD, 16'd1);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_NONE, 16'd2);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_CLEAR, 16'd0);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_ADD, 16'd2);
        queue_item(OP_TICK, 16'd0);
        // Fill the table, then try two adds too many.
        for (int i = 0; i <= CAPACITY; i++) queue_item(OP_ADD, 16'($urandom_range(1, 8)));
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_TICK, 16'd0);
        queue_item(OP_CLEAR, 16'd0);

        count = 0;
        while (count < 72) begin
            sel = $urandom_range(0, 99);
            count++;
            if (sel < 45) begin
                queue_item(OP_ADD, rand_life());
            end else if (sel < 85) begin
                queue_item(OP_TICK, rand_life());
            end else if (sel < 90) begin
                queue_item(OP_CLEAR, rand_life());
            end else if (sel < 93) begin
                queue_item(OP_NONE, rand_life());
            end else begin
                queue_extreme(sel[0] ? 16'h7FFF : 16'h8000, rand_life());
            end
        end
        queue_item(OP_TICK, 16'd0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_items.size() > 0 || s_valid) @(posedge aclk);
        while (emitted_particles.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("Covered %0d adds and %0d ticks, %0d particle results checked.",
                 n_adds, n_ticks, n_results);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/ptu_pkg.sv
hw/rtl/ptu_div.sv
hw/rtl/particle_table_update.sv
tb/testbench.sv
